// File: rtl/wbps_pkg.sv
// Shared types, constants and match function of the wildcard byte pattern search.
`timescale 1ns / 1ps
package wbps_pkg;

   localparam int BYTE_W        = 8;
   localparam int LEN_W         = 4;
   localparam int POS_W         = 32;
   localparam int START_W       = 32;
   localparam int ENABLE_W      = 8;
   localparam int VECTOR_W      = 64;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 64;

   localparam logic [BYTE_W-1:0] HIGH_NIBBLE = 8'hF0;
   localparam logic [BYTE_W-1:0] LOW_NIBBLE  = 8'h0F;

   localparam logic [LEN_W-1:0] LENGTH_RESET = 4'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LENGTH     = 3'd0,
      CSR_PRIMARY_VALUES     = 3'd1,
      CSR_PRIMARY_CARE_MASKS = 3'd2,
      CSR_SECOND_VALUES      = 3'd3,
      CSR_SECOND_CARE_MASKS  = 3'd4,
      CSR_SECOND_ENABLE      = 3'd5,
      CSR_START_OFFSET       = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [VECTOR_W-1:0] primary_values;
      logic [VECTOR_W-1:0] primary_care_masks;
      logic [VECTOR_W-1:0] second_values;
      logic [VECTOR_W-1:0] second_care_masks;
      logic [ENABLE_W-1:0] second_enable;
   } pattern_type;

   function automatic logic nibble_match(input logic [BYTE_W-1:0] data,
                                         input logic [BYTE_W-1:0] value,
                                         input logic [BYTE_W-1:0] mask);
      logic [BYTE_W-1:0] care;
      care = ({BYTE_W{|(mask & HIGH_NIBBLE)}} & HIGH_NIBBLE) |
             ({BYTE_W{|(mask & LOW_NIBBLE)}} & LOW_NIBBLE);
      return ((data ^ value) & care) == '0;
   endfunction

endpackage

// File: rtl/wbps_channels.sv
// Request and response channel interfaces of the wildcard byte pattern search.
`timescale 1ns / 1ps
interface wbps_req_if;
   logic                        valid;
   logic                        ready;
   logic [wbps_pkg::BYTE_W-1:0] data_byte;
   logic                        first_of_block;
   logic                        last_of_block;

   modport source (output valid, output data_byte, output first_of_block,
                   output last_of_block, input ready);
   modport sink (input valid, input data_byte, input first_of_block,
                 input last_of_block, output ready);
endinterface

interface wbps_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       match_found;
   logic [wbps_pkg::POS_W-1:0] match_position;
   logic                       search_failed;

   modport source (output valid, output match_found, output match_position,
                   output search_failed, input ready);
   modport sink (input valid, input match_found, input match_position,
                 input search_failed, output ready);
endinterface

// File: rtl/wbps_position_match.sv
// Per-position byte comparison against primary and second alternatives.
`timescale 1ns / 1ps
module wbps_position_match #(
   parameter int PATTERN_POSITIONS = 8
) (
   input  wbps_pkg::pattern_type         pattern,
   input  logic [wbps_pkg::BYTE_W-1:0]   data_byte,
   output logic [PATTERN_POSITIONS-1:0]  hits
);
   import wbps_pkg::*;

   always_comb begin
      for (int i = 0; i < PATTERN_POSITIONS; i++) begin
         hits[i] = nibble_match(data_byte, pattern.primary_values[BYTE_W*i +: BYTE_W],
                                pattern.primary_care_masks[BYTE_W*i +: BYTE_W]) |
                   (pattern.second_enable[i] &
                    nibble_match(data_byte, pattern.second_values[BYTE_W*i +: BYTE_W],
                                 pattern.second_care_masks[BYTE_W*i +: BYTE_W]));
      end
   end

endmodule

// File: rtl/wildcard_byte_pattern_search_top.sv
// Top level of the wildcard byte pattern search.
//
// Requests carry one byte of a block with first and last marks. A shift-and
// partial-match vector tracks every alignment, so the first occurrence in the
// block is found even where candidates overlap. Each request yields exactly
// one response: match_found with the offset of the match's first byte on the
// byte that completes the first match, or search_failed on a last byte of a
// block with no match. Offsets count from start_offset and saturate.
//
// A request passes the input register and then the result register to its response.
// Throughput: one request per cycle while responses are taken, set by the
// input and result registers with one pass of compare and shift logic between
// them. When the receiver stalls, the response holds and the input register
// still takes one more request; ready then drops until the response is taken.
// Reset clears the pipeline, the match state and all pattern registers
// (length one, values and masks zero, start offset zero). The user must write
// pattern registers through the csr port while the block is idle; not enforced.
`timescale 1ns / 1ps
module wildcard_byte_pattern_search_top #(
   parameter int PATTERN_POSITIONS = 8,
   parameter int OFFSET_BITS       = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]  csr_write_data,
   wbps_req_if.sink                         req_bus,
   wbps_rsp_if.source                       rsp_bus
);
   import wbps_pkg::*;

   localparam int CMP_W = (OFFSET_BITS > START_W) ? OFFSET_BITS : START_W;
   localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
   localparam logic [CMP_W-1:0] OFF_MAX_WIDE = CMP_W'(OFF_MAX);
   localparam logic [CMP_W-1:0] POS_MAX_WIDE = CMP_W'({POS_W{1'b1}});
   localparam logic [LEN_W-1:0] POS_LIMIT = LEN_W'(PATTERN_POSITIONS);

   logic [LEN_W-1:0]             pattern_length_ff;
   pattern_type                  pattern_ff;
   logic [START_W-1:0]           start_offset_ff;

   logic                         s1_valid_ff;
   logic [BYTE_W-1:0]            s1_byte_ff;
   logic                         s1_first_ff;
   logic                         s1_last_ff;

   logic [PATTERN_POSITIONS-1:0] pmv_ff;
   logic [PATTERN_POSITIONS-1:0] pmv_in;
   logic [OFFSET_BITS-1:0]       offset_ff;
   logic [OFFSET_BITS-1:0]       offset_in;
   logic                         found_ff;
   logic                         found_in;

   logic                         out_valid_ff;
   logic                         out_found_ff;
   logic [POS_W-1:0]             out_pos_ff;
   logic                         out_failed_ff;

   logic                         s1_advance;
   logic                         req_accept;
   logic [PATTERN_POSITIONS-1:0] hits;
   logic [PATTERN_POSITIONS-1:0] len_mask;
   logic [PATTERN_POSITIONS-1:0] top_mask;
   logic [PATTERN_POSITIONS-1:0] pmv_base;
   logic [LEN_W-1:0]             len_eff;
   logic [LEN_W-1:0]             len_m1;
   logic                         found_base;
   logic                         match_now;
   logic                         failed_now;
   logic [CMP_W-1:0]             start_wide;
   logic [OFFSET_BITS-1:0]       off;
   logic [OFFSET_BITS-1:0]       pos_off;
   logic [CMP_W-1:0]             pos_wide;
   logic [POS_W-1:0]             pos_sat;

   assign s1_advance    = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign req_accept    = req_bus.valid && req_bus.ready;

   wbps_position_match #(
      .PATTERN_POSITIONS(PATTERN_POSITIONS)
   ) u_match (
      .pattern   (pattern_ff),
      .data_byte (s1_byte_ff),
      .hits      (hits)
   );

   always_comb begin
      len_eff = (pattern_length_ff > POS_LIMIT) ? POS_LIMIT : pattern_length_ff;
      len_m1  = len_eff - LEN_W'(1);
      for (int i = 0; i < PATTERN_POSITIONS; i++) begin
         len_mask[i] = LEN_W'(i) < len_eff;
         top_mask[i] = LEN_W'(i + 1) == len_eff;
      end
      pmv_base   = s1_first_ff ? '0 : pmv_ff;
      found_base = s1_first_ff ? 1'b0 : found_ff;
      pmv_in     = ((pmv_base << 1) | PATTERN_POSITIONS'(1)) & hits & len_mask;
      match_now  = (|(pmv_in & top_mask)) && !found_base;
      found_in   = found_base || match_now;
      failed_now = s1_last_ff && !found_in;

      start_wide = CMP_W'(start_offset_ff);
      if (!s1_first_ff) begin
         off = offset_ff;
      end else if (start_wide > OFF_MAX_WIDE) begin
         off = OFF_MAX;
      end else begin
         off = OFFSET_BITS'(start_wide);
      end
      offset_in = (off == OFF_MAX) ? off : off + OFFSET_BITS'(1);

      pos_off  = (off >= OFFSET_BITS'(len_m1)) ? off - OFFSET_BITS'(len_m1) : '0;
      pos_wide = CMP_W'(pos_off);
      pos_sat  = (pos_wide > POS_MAX_WIDE) ? {POS_W{1'b1}} : pos_wide[POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= LENGTH_RESET;
         pattern_ff        <= '0;
         start_offset_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LENGTH:     pattern_length_ff <= csr_write_data[LEN_W-1:0];
            CSR_PRIMARY_VALUES:     pattern_ff.primary_values <= csr_write_data;
            CSR_PRIMARY_CARE_MASKS: pattern_ff.primary_care_masks <= csr_write_data;
            CSR_SECOND_VALUES:      pattern_ff.second_values <= csr_write_data;
            CSR_SECOND_CARE_MASKS:  pattern_ff.second_care_masks <= csr_write_data;
            CSR_SECOND_ENABLE:      pattern_ff.second_enable <= csr_write_data[ENABLE_W-1:0];
            CSR_START_OFFSET:       start_offset_ff <= csr_write_data[START_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pmv_ff       <= '0;
         offset_ff    <= '0;
         found_ff     <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            out_valid_ff <= 1'b1;
            pmv_ff       <= pmv_in;
            offset_ff    <= offset_in;
            found_ff     <= found_in;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff  <= req_bus.data_byte;
         s1_first_ff <= req_bus.first_of_block;
         s1_last_ff  <= req_bus.last_of_block;
      end
      if (s1_advance) begin
         out_found_ff  <= match_now;
         out_pos_ff    <= match_now ? pos_sat : '0;
         out_failed_ff <= failed_now;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.match_found    = out_found_ff;
   assign rsp_bus.match_position = out_pos_ff;
   assign rsp_bus.search_failed  = out_failed_ff;

   a_found_not_failed: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_found_ff && out_failed_ff))
      else $error("match and failure reported together");

   a_match_sets_found: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && match_now) |=> found_ff)
      else $error("match not recorded in state");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (s1_valid_ff && out_valid_ff && !rsp_bus.ready))
      else $error("request refused without a stall");

endmodule

// File: tb/sv/wildcard_byte_pattern_search_top_test.sv
// Self-checking testbench for the wildcard byte pattern search, predicting every response.
`timescale 1ns / 1ps
module wildcard_byte_pattern_search_top_test;
   import wbps_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [POS_W-1:0] OFFSET_MAX = '1;

   typedef struct {
      logic             found;
      logic [POS_W-1:0] position;
      logic             failed;
   } scan_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PATTERN_LENGTH;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   wbps_req_if req_if ();
   wbps_rsp_if rsp_if ();

   wildcard_byte_pattern_search_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_if),
      .rsp_bus          (rsp_if)
   );

   always #1 clock = ~clock;

   logic [LEN_W-1:0]    cfg_length = LENGTH_RESET;
   logic [VECTOR_W-1:0] cfg_primary = '0;
   logic [VECTOR_W-1:0] cfg_primary_care = '0;
   logic [VECTOR_W-1:0] cfg_second = '0;
   logic [VECTOR_W-1:0] cfg_second_care = '0;
   logic [ENABLE_W-1:0] cfg_second_enable = '0;
   logic [START_W-1:0]  cfg_start = '0;

   logic [7:0]       partial_hits = '0;
   logic [POS_W-1:0] next_offset = '0;
   logic             match_reported = 1'b0;

   scan_result_type pending_scan_results[$];
   scan_result_type oldest_scan;
   int error_count = 0;
   int items_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycle_count = 0;

   function automatic logic byte_fits(input logic [BYTE_W-1:0] data,
                                      input logic [BYTE_W-1:0] value,
                                      input logic [BYTE_W-1:0] mask);
      logic [BYTE_W-1:0] care;
      care = {{4{mask[7:4] != 4'h0}}, {4{mask[3:0] != 4'h0}}};
      return ((data ^ value) & care) == 8'h00;
   endfunction

   function automatic scan_result_type predict_scan_result(input logic [BYTE_W-1:0] data,
                                                           input logic first,
                                                           input logic last);
      logic [POS_W-1:0] offset;
      logic [7:0]       hits;
      logic [7:0]       length_mask;
      int unsigned      length;
      scan_result_type  result;
      result = '{found: 1'b0, position: '0, failed: 1'b0};
      if (first) begin
         partial_hits = '0;
         match_reported = 1'b0;
         offset = cfg_start;
      end else begin
         offset = next_offset;
      end
      length = (cfg_length > 8) ? 8 : cfg_length;
      hits = '0;
      for (int i = 0; i < length; i++) begin
         hits[i] = byte_fits(data, cfg_primary[8*i +: 8], cfg_primary_care[8*i +: 8]) ||
                   (cfg_second_enable[i] &&
                    byte_fits(data, cfg_second[8*i +: 8], cfg_second_care[8*i +: 8]));
      end
      length_mask = 8'((16'd1 << length) - 16'd1);
      partial_hits = {partial_hits[6:0], 1'b1} & hits & length_mask;
      if (length > 0 && !match_reported && partial_hits[length-1]) begin
         result.found = 1'b1;
         result.position = (offset >= POS_W'(length - 1)) ? offset - POS_W'(length - 1) : '0;
         match_reported = 1'b1;
      end
      result.failed = last && !match_reported;
      next_offset = (offset == OFFSET_MAX) ? offset : offset + 1'b1;
      return result;
   endfunction

   always @(posedge clock) rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_scan_results.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            oldest_scan = pending_scan_results.pop_front();
            if (rsp_if.match_found !== oldest_scan.found) begin
               $error("match_found: expected %0d, got %0d", oldest_scan.found,
                      rsp_if.match_found);
               error_count++;
            end
            if (rsp_if.match_position !== oldest_scan.position) begin
               $error("match_position: expected %h, got %h", oldest_scan.position,
                      rsp_if.match_position);
               error_count++;
            end
            if (rsp_if.search_failed !== oldest_scan.failed) begin
               $error("search_failed: expected %0d, got %0d", oldest_scan.failed,
                      rsp_if.search_failed);
               error_count++;
            end
         end
      end
   end

   task automatic send_request(input logic [BYTE_W-1:0] data, input logic first,
                               input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= data;
      req_if.first_of_block <= first;
      req_if.last_of_block <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_scan_results.push_back(predict_scan_result(data, first, last));
      items_sent++;
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_scan_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      case (index)
         CSR_PATTERN_LENGTH:     cfg_length = value[LEN_W-1:0];
         CSR_PRIMARY_VALUES:     cfg_primary = value;
         CSR_PRIMARY_CARE_MASKS: cfg_primary_care = value;
         CSR_SECOND_VALUES:      cfg_second = value;
         CSR_SECOND_CARE_MASKS:  cfg_second_care = value;
         CSR_SECOND_ENABLE:      cfg_second_enable = value[ENABLE_W-1:0];
         CSR_START_OFFSET:       cfg_start = value[START_W-1:0];
         default:                ;
      endcase
   endtask

   task automatic write_pattern(input logic [CSR_DATA_W-1:0] length_word,
                                input logic [CSR_DATA_W-1:0] primary,
                                input logic [CSR_DATA_W-1:0] primary_care,
                                input logic [CSR_DATA_W-1:0] second,
                                input logic [CSR_DATA_W-1:0] second_care,
                                input logic [CSR_DATA_W-1:0] enable_word,
                                input logic [CSR_DATA_W-1:0] start_word);
      wait_idle();
      write_register(CSR_PATTERN_LENGTH, length_word);
      write_register(CSR_PRIMARY_VALUES, primary);
      write_register(CSR_PRIMARY_CARE_MASKS, primary_care);
      write_register(CSR_SECOND_VALUES, second);
      write_register(CSR_SECOND_CARE_MASKS, second_care);
      write_register(CSR_SECOND_ENABLE, enable_word);
      write_register(CSR_START_OFFSET, start_word);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [VECTOR_W-1:0] random_care_masks();
      logic [VECTOR_W-1:0] masks;
      for (int i = 0; i < 16; i++) begin
         masks[4*i +: 4] = ($urandom_range(4) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
      end
      return masks;
   endfunction

   function automatic logic [VECTOR_W-1:0] random_values();
      int unsigned style;
      style = $urandom_range(7);
      if (style == 0) return '0;
      if (style == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [VECTOR_W-1:0] random_masks();
      int unsigned style;
      style = $urandom_range(7);
      if (style == 0) return '1;
      if (style == 1) return '0;
      return random_care_masks();
   endfunction

   function automatic logic [BYTE_W-1:0] pattern_byte(input int position);
      logic [BYTE_W-1:0] value;
      logic [BYTE_W-1:0] mask;
      logic [BYTE_W-1:0] care;
      int                slot;
      slot = position % 8;
      if (cfg_second_enable[slot] && $urandom_range(1) == 1) begin
         value = cfg_second[8*slot +: 8];
         mask = cfg_second_care[8*slot +: 8];
      end else begin
         value = cfg_primary[8*slot +: 8];
         mask = cfg_primary_care[8*slot +: 8];
      end
      care = {{4{mask[7:4] != 4'h0}}, {4{mask[3:0] != 4'h0}}};
      return (value & care) | (8'($urandom) & ~care);
   endfunction

   task automatic random_pattern();
      logic [CSR_DATA_W-1:0] length_word;
      logic [CSR_DATA_W-1:0] enable_word;
      logic [START_W-1:0]    start;
      int unsigned           pick;
      length_word = {$urandom, $urandom};
      pick = $urandom_range(9);
      if (pick == 0) length_word[LEN_W-1:0] = '0;
      else if (pick == 9) length_word[LEN_W-1:0] = LEN_W'($urandom_range(9, 15));
      else length_word[LEN_W-1:0] = LEN_W'(pick);
      enable_word = {$urandom, $urandom};
      pick = $urandom_range(5);
      if (pick == 0) enable_word[ENABLE_W-1:0] = '0;
      else if (pick == 1) enable_word[ENABLE_W-1:0] = '1;
      pick = $urandom_range(5);
      if (pick == 0) start = '0;
      else if (pick == 1) start = OFFSET_MAX - START_W'($urandom_range(0, 30));
      else start = $urandom;
      write_pattern(length_word, random_values(), random_masks(), random_values(),
                    random_masks(), enable_word, {$urandom, start});
   endtask

   task automatic send_block();
      int                block_size;
      int                length;
      int                match_at;
      logic [BYTE_W-1:0] data;
      block_size = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      length = (cfg_length > 8) ? 8 : cfg_length;
      match_at = (length > 0 && $urandom_range(3) != 0) ? $urandom_range(0, block_size - 1) : -1;
      for (int j = 0; j < block_size; j++) begin
         if (match_at >= 0 && j >= match_at && j < match_at + length) begin
            data = pattern_byte(j - match_at);
         end else if ($urandom_range(1) == 1) begin
            data = pattern_byte($urandom_range(0, 7));
         end else begin
            data = 8'($urandom);
         end
         send_request(data,
                      (j == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0),
                      (j == block_size - 1) ? ($urandom_range(19) != 0)
                                            : ($urandom_range(49) == 0));
      end
   endtask

   task automatic test_reset_defaults();
      send_request(8'h00, 1'b0, 1'b0);
      send_request(8'hFF, 1'b0, 1'b0);
      send_request(8'h5A, 1'b0, 1'b1);
   endtask

   task automatic test_overlap_and_alternatives();
      write_pattern(64'h0000_0000_0000_0003, 64'h0000_0000_0042_4141,
                    64'h0000_0000_00F0_FFFF, 64'h0000_0000_007E_0000,
                    64'h0000_0000_000F_0000, 64'hFFFF_FFFF_FFFF_FF04,
                    64'hDEAD_BEEF_0000_0010);
      send_request(8'h41, 1'b1, 1'b0);
      send_request(8'h41, 1'b0, 1'b0);
      send_request(8'h41, 1'b0, 1'b0);
      send_request(8'h4F, 1'b0, 1'b0);
      send_request(8'h41, 1'b0, 1'b0);
      send_request(8'h41, 1'b0, 1'b0);
      send_request(8'h40, 1'b0, 1'b1);
      send_request(8'hFF, 1'b1, 1'b0);
      send_request(8'h41, 1'b0, 1'b0);
      send_request(8'h41, 1'b0, 1'b0);
      send_request(8'h0E, 1'b0, 1'b1);
      send_request(8'h00, 1'b1, 1'b1);
   endtask

   task automatic test_zero_length();
      write_pattern(64'hFFFF_FFFF_FFFF_FFF0, '1, '0, '1, '0, '1, '1);
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'hFF, 1'b0, 1'b1);
   endtask

   task automatic test_offset_saturation();
      write_pattern(64'h0000_0000_0000_000C, '0, '0, '0, '0, '0, 64'h0000_0000_FFFF_FFFB);
      for (int j = 0; j < 8; j++) begin
         send_request(j[0] ? 8'hFF : 8'h00, j == 0, j == 7);
      end
   endtask

   task automatic test_random_traffic(input int item_count);
      int target;
      target = items_sent + item_count;
      while (items_sent < target) begin
         random_pattern();
         repeat ($urandom_range(4, 12)) send_block();
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.first_of_block = 1'b0;
      req_if.last_of_block = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 9;
      recv_stall_pct = 57;
      test_reset_defaults();
      test_overlap_and_alternatives();
      test_zero_length();
      test_offset_saturation();
      test_random_traffic(660);

      send_idle_pct = 57;
      recv_stall_pct = 9;
      test_random_traffic(660);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_traffic(680);

      wait_idle();
      repeat (6) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
